### sv/uqd_pkg.sv
// Shared widths, register indexes and the queue entry type for the dithered quantizer.
package uqd_pkg;

    localparam int PIXEL_W = 8;
    localparam int RAND_W = 16;
    localparam int LEVEL_W = 9;
    localparam int JIT_SHIFT = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = LEVEL_W;
    localparam int QUEUE_DEPTH = 2;

    localparam int GRAY_LEVELS_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_ENABLE = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 9'd256;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 9'd2;
    localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hFF;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [RAND_W-1:0]  rnd;
        logic [LEVEL_W-1:0] levels;
        logic               dither;
        logic               add;
    } item_t;

endpackage

### sv/uqd_front.sv
// Front end: accept a pixel beat, settle level count and jitter sign, push to the queue.
module uqd_front
    import uqd_pkg::*;
#(
    parameter int GRAY_LEVELS = GRAY_LEVELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIXEL_W-1:0] pixel_value,
    input  logic [RAND_W-1:0]  random_fraction,
    input  logic               channel_start,
    input  logic [LEVEL_W-1:0] level_count,
    input  logic               dither_enable,
    input  logic               queue_full,
    output logic               push,
    output item_t              entry
);

    localparam int LEVEL_TOP = (1 << LEVEL_W) - 1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX =
        LEVEL_W'((GRAY_LEVELS > LEVEL_TOP) ? LEVEL_TOP : GRAY_LEVELS);

    logic               add_next_reg;
    logic               add_next_next;
    logic               add_now;
    logic [LEVEL_W-1:0] levels;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign add_now  = channel_start || add_next_reg;

    always_comb
    begin
        if (level_count < LEVEL_MIN)
        begin
            levels = LEVEL_MIN;
        end
        else if (level_count > LEVEL_MAX)
        begin
            levels = LEVEL_MAX;
        end
        else
        begin
            levels = level_count;
        end
    end

    always_comb
    begin
        entry.pixel  = pixel_value;
        entry.rnd    = random_fraction;
        entry.levels = levels;
        entry.dither = dither_enable;
        entry.add    = add_now;
    end

    // flip the sign only when jitter is actually applied
    always_comb
    begin
        add_next_next = add_next_reg;
        if (push)
        begin
            add_next_next = dither_enable ? !add_now : add_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_next_reg <= 1'b1;
        end
        else
        begin
            add_next_reg <= add_next_next;
        end
    end

endmodule

### sv/uqd_fifo.sv
// Small queue between the front end and the back end.
module uqd_fifo
    import uqd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/uqd_div.sv
// Restoring divider, one quotient bit per cycle, shared by jitter and midpoint math.
module uqd_div
#(
    parameter int DW = 25,
    parameter int QW = 23
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DW-1:0]              den,
    input  logic [DW-1:0]              rem_init,
    input  logic [QW-1:0]              sr_init,
    input  logic [$clog2(QW+1)-1:0]    steps,
    output logic                       busy,
    output logic [QW-1:0]              quo
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] sr_reg;
    logic [QW-1:0] sr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign busy = (cnt_reg != '0);
    assign quo  = sr_reg;

    // bring down the next numerator bit, subtract when it fits
    assign trial = {rem_reg, sr_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next = rem_reg;
        sr_next  = sr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = rem_init;
            sr_next  = sr_init;
            cnt_next = steps;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DW-1:0];
                sr_next  = {sr_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                sr_next  = {sr_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_reg <= rem_next;
        sr_reg  <= sr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/uqd_back.sv
// Back end: jitter, clamp, bin index and bin midpoint for one queued pixel at a time.
module uqd_back
    import uqd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              head,
    input  logic               queue_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIXEL_W-1:0] quantized_value
);

    localparam int VW = FRACTION_BITS + PIXEL_W;
    localparam int JW = FRACTION_BITS + JIT_SHIFT;
    localparam int QW = JW;
    localparam int DW = RAND_W + LEVEL_W;
    localparam int PW = VW + LEVEL_W;
    localparam int CW = $clog2(QW + 1);
    localparam int NW = LEVEL_W + 10;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_JDIV   = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_QSTART = 3'd4;
    localparam logic [2:0] ST_QDIV   = 3'd5;
    localparam logic [2:0] ST_HOLD   = 3'd6;

    localparam logic [VW-1:0] VJ_TOP = {PIXEL_MAX, {FRACTION_BITS{1'b0}}};

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    item_t              cur_reg;
    logic [VW-1:0]      vj_reg;
    logic [VW-1:0]      vj_next;
    logic [PW-1:0]      prod_reg;
    logic [PIXEL_W-1:0] qv_reg;
    logic [PIXEL_W-1:0] qv_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXEL_W-1:0] out_data_reg;
    logic               out_load;

    logic               div_start;
    logic [DW-1:0]      div_den;
    logic [DW-1:0]      div_rem_init;
    logic [QW-1:0]      div_sr_init;
    logic [CW-1:0]      div_steps;
    logic               div_busy;
    logic [QW-1:0]      div_quo;

    logic [JW-1:0]      jit;
    logic [VW-1:0]      vj_base;
    logic [VW:0]        vj_sum;
    logic [VW-1:0]      jit_ext;
    logic [LEVEL_W-1:0] k_raw;
    logic [LEVEL_W-1:0] k_bin;
    logic [NW-1:0]      q_num;

    assign pop             = (state_reg == ST_IDLE) && !queue_empty;
    assign out_valid       = out_valid_reg;
    assign quantized_value = out_data_reg;
    assign out_load        = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);

    // jitter denominator is 65535 * L, midpoint denominator is 2 * L
    always_comb
    begin
        if (state_reg == ST_QSTART)
        begin
            div_start    = 1'b1;
            div_den      = {{(DW - LEVEL_W - 1){1'b0}}, cur_reg.levels, 1'b0};
            div_rem_init = {{(DW - (NW - LEVEL_W)){1'b0}}, q_num[NW-1:LEVEL_W]};
            div_sr_init  = {q_num[LEVEL_W-1:0], {(QW - LEVEL_W){1'b0}}};
            div_steps    = CW'(LEVEL_W);
        end
        else
        begin
            div_start    = pop && head.dither;
            div_den      = {head.levels, {RAND_W{1'b0}}} - {{RAND_W{1'b0}}, head.levels};
            div_rem_init = {{LEVEL_W{1'b0}}, head.rnd};
            div_sr_init  = '0;
            div_steps    = CW'(QW);
        end
    end

    uqd_div #(
        .DW (DW),
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (div_den),
        .rem_init (div_rem_init),
        .sr_init  (div_sr_init),
        .steps    (div_steps),
        .busy     (div_busy),
        .quo      (div_quo)
    );

    // apply jitter and clamp to the pixel range
    always_comb
    begin
        jit     = cur_reg.dither ? div_quo : '0;
        vj_base = {cur_reg.pixel, {FRACTION_BITS{1'b0}}};
        jit_ext = {{(VW - JW){1'b0}}, jit};
        vj_sum  = {1'b0, vj_base} + {1'b0, jit_ext};
        if (cur_reg.add)
        begin
            vj_next = (vj_sum > {1'b0, VJ_TOP}) ? VJ_TOP : vj_sum[VW-1:0];
        end
        else
        begin
            vj_next = (jit_ext > vj_base) ? '0 : vj_base - jit_ext;
        end
    end

    // bin index and midpoint numerator 256*(2k+1) + L
    always_comb
    begin
        k_raw = prod_reg[PW-1:VW];
        k_bin = (k_raw >= cur_reg.levels) ? cur_reg.levels - 1'b1 : k_raw;
        q_num = {1'b0, k_bin, 1'b1, {PIXEL_W{1'b0}}} + {{(NW - LEVEL_W){1'b0}}, cur_reg.levels};
        qv_next = div_quo[LEVEL_W-1] ? PIXEL_MAX : div_quo[PIXEL_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = head.dither ? ST_JDIV : ST_APPLY;
                end
            end
            ST_JDIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_QSTART;
            end
            ST_QSTART:
            begin
                state_next = ST_QDIV;
            end
            ST_QDIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (state_reg == ST_APPLY)
        begin
            vj_reg <= vj_next;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= vj_reg * cur_reg.levels;
        end
        if ((state_reg == ST_QDIV) && !div_busy)
        begin
            qv_reg <= qv_next;
        end
        if (out_load)
        begin
            out_data_reg <= qv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/uniform_quantizer_with_dither.sv
// Top level of the dithered uniform gray-level quantizer: config registers and wiring.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     pixel_value, random_fraction, channel_start
//   output    out_valid / out_stall   quantized_value
//   config    cfg_we                  cfg_index, cfg_data
//
// With dither on, a pixel passes pop, the jitter divide, apply, multiply, divide start, the
// midpoint divide and output load, both divides on the shared one-bit-per-cycle divider;
// with dither off it skips the jitter divide. Output load waits while the output stalls.
// The back end pops the next pixel only after it has loaded the previous one to the output.
// Reset clears the sign state to "add", level_count to 256 and dither off.
// A two-beat queue lets input beats land while the back end works or the output stalls.
module uniform_quantizer_with_dither
    import uqd_pkg::*;
#(
    parameter int GRAY_LEVELS   = GRAY_LEVELS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIXEL_W-1:0]     pixel_value,
    input  logic [RAND_W-1:0]      random_fraction,
    input  logic                   channel_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIXEL_W-1:0]     quantized_value,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [LEVEL_W-1:0] level_count_reg;
    logic [LEVEL_W-1:0] level_count_next;
    logic               dither_enable_reg;
    logic               dither_enable_next;

    logic  push;
    item_t push_data;
    item_t head;
    logic  queue_full;
    logic  queue_empty;
    logic  pop;

    always_comb
    begin
        level_count_next   = level_count_reg;
        dither_enable_next = dither_enable_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_COUNT:
                begin
                    level_count_next = cfg_data[LEVEL_W-1:0];
                end
                REG_DITHER_ENABLE:
                begin
                    dither_enable_next = cfg_data[0];
                end
                default:
                begin
                    level_count_next = level_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg   <= LEVEL_RESET;
            dither_enable_reg <= 1'b0;
        end
        else
        begin
            level_count_reg   <= level_count_next;
            dither_enable_reg <= dither_enable_next;
        end
    end

    uqd_front #(
        .GRAY_LEVELS (GRAY_LEVELS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_value     (pixel_value),
        .random_fraction (random_fraction),
        .channel_start   (channel_start),
        .level_count     (level_count_reg),
        .dither_enable   (dither_enable_reg),
        .queue_full      (queue_full),
        .push            (push),
        .entry           (push_data)
    );

    uqd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    uqd_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .queue_empty     (queue_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quantized_value (quantized_value)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the dithered uniform gray-level quantizer.
module tb_top;
    import uqd_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int PIXELS_PER_PHASE = 110;

    class quant_tracker;
        logic [LEVEL_W-1:0] levels;
        logic               dither_on;
        logic               add_next;
        logic [PIXEL_W-1:0] expected_levels[$];
        int                 fails;
        int                 reported;

        function new();
            levels = LEVEL_RESET;
            dither_on = 1'b0;
            add_next = 1'b1;
            fails = 0;
            reported = 0;
        endfunction

        function void set_levels(logic [LEVEL_W-1:0] value);
            levels = value;
        endfunction

        function void set_dither(logic value);
            dither_on = value;
        endfunction

        function void flag(string msg);
            fails++;
            if (reported < 10)
            begin
                $display("ERROR @%0t: %s", $time, msg);
                reported++;
            end
        endfunction

        // Jitter, clamp, bin and midpoint in 16-bit fraction fixed point.
        function logic [PIXEL_W-1:0] predict_level(logic [PIXEL_W-1:0] pix,
                                                   logic [RAND_W-1:0] rnd, logic start);
            longint unsigned lv, one, top, vj, jit, bin, mid;
            lv = levels;
            if (lv < LEVEL_MIN)
                lv = LEVEL_MIN;
            if (lv > GRAY_LEVELS_DEF)
                lv = GRAY_LEVELS_DEF;
            one = longint'(1) << FRACTION_BITS_DEF;
            top = 255 * one;
            vj = longint'(pix) * one;
            if (start)
                add_next = 1'b1;
            if (dither_on)
            begin
                jit = (longint'(rnd) * 128 * one) / (65535 * lv);
                if (add_next)
                begin
                    vj = vj + jit;
                    if (vj > top)
                        vj = top;
                end
                else
                    vj = (jit > vj) ? 0 : vj - jit;
                add_next = ~add_next;
            end
            bin = (vj * lv) / (256 * one);
            if (bin >= lv)
                bin = lv - 1;
            mid = (256 * (2 * bin + 1) + lv) / (2 * lv);
            if (mid > 255)
                mid = 255;
            return mid[PIXEL_W-1:0];
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] pix, logic [RAND_W-1:0] rnd,
                                 logic start);
            expected_levels.push_back(predict_level(pix, rnd, start));
        endfunction

        function void check_level(logic [PIXEL_W-1:0] actual);
            logic [PIXEL_W-1:0] want;
            if (expected_levels.size() == 0)
            begin
                flag($sformatf("unexpected quantized_value %0d", actual));
                return;
            end
            want = expected_levels.pop_front();
            if (actual !== want)
                flag($sformatf("quantized_value expected %0d actual %0d", want, actual));
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel_value;
    logic [RAND_W-1:0]      random_fraction;
    logic                   channel_start;
    logic                   out_valid;
    logic                   out_stall;
    logic [PIXEL_W-1:0]     quantized_value;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    quant_tracker trk = new();
    bit long_hold_req = 1'b0;
    int burst_left = 0;

    uniform_quantizer_with_dither DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_value     (pixel_value),
        .random_fraction (random_fraction),
        .channel_start   (channel_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .quantized_value (quantized_value),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            trk.check_level(quantized_value);
    end

    // Receiver: segments of steady, light or heavy stall, plus long hold-offs on request.
    initial
    begin
        int seg_len;
        int stall_pct;
        out_stall = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                seg_len = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 70;
                endcase
                repeat (seg_len)
                begin
                    out_stall <= ($urandom_range(1, 100) <= stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one beat and hold it until accepted; close the burst with a random gap.
    task automatic send_pixel(logic [PIXEL_W-1:0] pix, logic [RAND_W-1:0] rnd,
                              logic start);
        in_valid <= 1'b1;
        pixel_value <= pix;
        random_fraction <= rnd;
        channel_start <= start;
        do
            @(posedge clk);
        while (in_stall);
        trk.note_pixel(pix, rnd, start);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (trk.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [LEVEL_W-1:0] levels, logic dither);
        cfg_we <= 1'b1;
        cfg_index <= REG_LEVEL_COUNT;
        cfg_data <= levels;
        @(posedge clk);
        cfg_index <= REG_DITHER_ENABLE;
        // upper bits are don't-care for the one-bit register
        cfg_data <= {(CFG_DATA_W-1)'($urandom_range(0, 255)), dither};
        @(posedge clk);
        cfg_we <= 1'b0;
        trk.set_levels(levels);
        trk.set_dither(dither);
        @(posedge clk);
    endtask

    initial
    begin
        logic [LEVEL_W-1:0] phase_levels[RANDOM_PHASES];
        bit                 phase_dither[RANDOM_PHASES];
        logic [PIXEL_W-1:0] pix;
        logic [RAND_W-1:0]  rnd;
        int                 waited;

        phase_levels = '{9'd0, 9'd511, 9'd2, 9'd256, 9'd1, 9'd3, 9'd257, 9'd0};
        phase_dither = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        phase_levels[RANDOM_PHASES-1] = LEVEL_W'($urandom_range(4, 255));

        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_value = '0;
        random_fraction = '0;
        channel_start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LEVEL_COUNT;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 256 levels, no dither
        send_pixel(8'd0, 16'd0, 1'b1);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        send_pixel(8'd128, 16'd12345, 1'b0);
        wait_idle();

        // two levels, full jitter: add-clamp at top, subtract-clamp at zero
        write_config(9'd2, 1'b1);
        send_pixel(8'd0, 16'hFFFF, 1'b1);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd255, 16'hFFFF, 1'b1);
        send_pixel(8'd128, 16'd0, 1'b0);
        send_pixel(8'd127, 16'd1, 1'b1);
        wait_idle();

        // level count above the maximum saturates
        write_config(9'd511, 1'b1);
        send_pixel(8'd255, 16'hFFFF, 1'b1);
        send_pixel(8'd0, 16'hFFFF, 1'b0);
        send_pixel(8'd200, 16'd32768, 1'b0);
        wait_idle();

        // level count below two, dither off
        write_config(9'd1, 1'b0);
        send_pixel(8'd127, 16'hFFFF, 1'b1);
        send_pixel(8'd128, 16'd0, 1'b0);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        wait_idle();

        write_config(9'd3, 1'b1);
        send_pixel(8'd85, 16'd40000, 1'b1);
        send_pixel(8'd170, 16'd40000, 1'b0);
        send_pixel(8'd0, 16'd0, 1'b0);
        send_pixel(8'd255, 16'hFFFF, 1'b0);
        wait_idle();

        write_config(9'd257, 1'b0);
        send_pixel(8'd1, 16'd0, 1'b0);
        send_pixel(8'd254, 16'd0, 1'b1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_config(phase_levels[ph], phase_dither[ph]);
            if (ph == 1 || ph == 5)
                long_hold_req = 1'b1;
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 7))
                    0: pix = 8'd0;
                    1: pix = PIXEL_MAX;
                    default: pix = PIXEL_W'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 7))
                    0: rnd = 16'd0;
                    1: rnd = 16'hFFFF;
                    default: rnd = RAND_W'($urandom_range(0, 65535));
                endcase
                send_pixel(pix, rnd, $urandom_range(0, 15) == 0);
                // pause mid-phase until the pipe is empty
                if (ph == 3 && i == PIXELS_PER_PHASE / 2)
                    wait_idle();
            end
            wait_idle();
        end

        waited = 0;
        while (trk.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (trk.pending() != 0)
            trk.flag($sformatf("%0d expected results never arrived", trk.pending()));

        if (trk.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
sv/uqd_pkg.sv
sv/uqd_front.sv
sv/uqd_fifo.sv
sv/uqd_div.sv
sv/uqd_back.sv
sv/uniform_quantizer_with_dither.sv
tb/tb_top.sv
